@@ rtl/core/cdr_pkg.sv @@
`timescale 1ns / 1ps

package cdr_pkg;

    // Input item kinds (tuser)
    localparam logic [1:0] OP_FRAME  = 2'd0;
    localparam logic [1:0] OP_MS     = 2'd1;
    localparam logic [1:0] OP_STATUS = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_DIAG_REQ_ID  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIAG_RESP_ID = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT_ID = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STATUS_ID    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALERT_ID     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DID_FIRST    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DID_SECOND   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS   = 4'd7;

    // Reset values of the registers
    localparam logic [10:0] RST_DIAG_REQ_ID  = 11'h7C0;
    localparam logic [10:0] RST_DIAG_RESP_ID = 11'h7C8;
    localparam logic [10:0] RST_HEARTBEAT_ID = 11'h081;
    localparam logic [10:0] RST_STATUS_ID    = 11'h180;
    localparam logic [10:0] RST_ALERT_ID     = 11'h001;
    localparam logic [15:0] RST_DID_FIRST    = 16'h0100;
    localparam logic [15:0] RST_DID_SECOND   = 16'h0101;
    localparam logic [15:0] RST_TIMEOUT_MS   = 16'd350;

    // UDS service and response codes
    localparam logic [7:0] SID_READ_DID  = 8'h22;
    localparam logic [7:0] SID_READ_DTC  = 8'h19;
    localparam logic [7:0] SID_CLEAR_DTC = 8'h14;
    localparam logic [7:0] POS_OFFSET    = 8'h40;
    localparam logic [7:0] NEG_RESP      = 8'h7F;
    localparam logic [7:0] NRC_NOT_SUPP  = 8'h10;
    localparam logic [7:0] NRC_RANGE     = 8'h31;
    localparam logic [7:0] DTC_SUB_DEF   = 8'h02;
    localparam logic [7:0] DTC_STATUS    = 8'hFF;

    localparam logic [15:0] FAULT_CODE   = 16'h4003;
    localparam logic [7:0]  PARTNER_CODE = 8'h01;

    localparam logic [3:0]  STATUS_LEN = 4'd3;
    localparam logic [3:0]  ALERT_LEN  = 4'd2;
    localparam logic [15:0] AGE_MAX    = 16'hFFFF;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // One queued job: first frame, plus a flag for a trailing alert frame
    typedef struct packed {
        logic [10:0] id;
        logic [3:0]  len;
        logic [63:0] data;
        logic        alert;
    } cdr_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } cdr_qstat_t;

endpackage

@@ rtl/core/cdr_fifo.sv @@
`timescale 1ns / 1ps

module cdr_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cdr_pkg::cdr_entry_t wr_entry,
    input  logic              pop,
    output cdr_pkg::cdr_entry_t rd_entry,
    output cdr_pkg::cdr_qstat_t stat
);
    import cdr_pkg::*;

    cdr_entry_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   cnt_reg, cnt_next;

    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign rd_entry   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

@@ rtl/core/cdr_front.sv @@
`timescale 1ns / 1ps

module cdr_front (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_valid,
    input  logic [cdr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cdr_pkg::CFG_DATA_W-1:0]     cfg_data,
    // accepted item
    input  logic                               in_take,
    input  logic [1:0]                         opcode,
    input  logic [10:0]                        frame_id,
    input  logic [3:0]                         frame_len,
    input  logic [63:0]                        frame_data,
    input  logic [6:0]                         sample_first,
    input  logic [5:0]                         sample_second,
    input  logic                               stale_flag,
    // towards the queue
    output logic                               push,
    output cdr_pkg::cdr_entry_t                entry,
    output logic [10:0]                        alert_id
);
    import cdr_pkg::*;

    logic [10:0] req_id_reg, resp_id_reg, hb_id_reg, status_id_reg, alert_id_reg;
    logic [15:0] did_first_reg, did_second_reg, timeout_reg;

    logic        hb_seen_reg, hb_seen_next;
    logic [15:0] hb_age_reg, hb_age_next;
    logic        fault_reg, fault_next;
    logic [6:0]  st_first_reg, st_first_next;
    logic [5:0]  st_second_reg, st_second_next;

    logic [3:0]  dlc;
    logic [7:0]  b [8];
    logic [3:0]  pci_len;
    logic [15:0] did;
    logic        req_ok;

    assign alert_id = alert_id_reg;

    // register writes; an index beyond the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_id_reg     <= RST_DIAG_REQ_ID;
            resp_id_reg    <= RST_DIAG_RESP_ID;
            hb_id_reg      <= RST_HEARTBEAT_ID;
            status_id_reg  <= RST_STATUS_ID;
            alert_id_reg   <= RST_ALERT_ID;
            did_first_reg  <= RST_DID_FIRST;
            did_second_reg <= RST_DID_SECOND;
            timeout_reg    <= RST_TIMEOUT_MS;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DIAG_REQ_ID:  req_id_reg     <= cfg_data[10:0];
                REG_DIAG_RESP_ID: resp_id_reg    <= cfg_data[10:0];
                REG_HEARTBEAT_ID: hb_id_reg      <= cfg_data[10:0];
                REG_STATUS_ID:    status_id_reg  <= cfg_data[10:0];
                REG_ALERT_ID:     alert_id_reg   <= cfg_data[10:0];
                REG_DID_FIRST:    did_first_reg  <= cfg_data;
                REG_DID_SECOND:   did_second_reg <= cfg_data;
                REG_TIMEOUT_MS:   timeout_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // request bytes, zero beyond the DLC (clamped at 8)
    always_comb
    begin
        dlc = (frame_len > 4'd8) ? 4'd8 : frame_len;
        for (int i = 0; i < 8; i++)
        begin
            b[i] = (4'(i) < dlc) ? frame_data[8*i +: 8] : 8'h00;
        end
        pci_len = b[0][3:0];
        did     = {b[2], b[3]};
        req_ok  = (dlc != 4'd0) && (b[0][7:4] == 4'h0)
                  && (pci_len != 4'd0) && (pci_len <= 4'd7);
    end

    always_comb
    begin
        hb_seen_next   = hb_seen_reg;
        hb_age_next    = hb_age_reg;
        fault_next     = fault_reg;
        st_first_next  = st_first_reg;
        st_second_next = st_second_reg;
        push           = 1'b0;
        entry.id       = resp_id_reg;
        entry.len      = 4'd0;
        entry.data     = '0;
        entry.alert    = 1'b0;

        if (in_take)
        begin
            unique case (opcode)
                OP_FRAME:
                begin
                    if (frame_id == hb_id_reg)
                    begin
                        hb_seen_next = 1'b1;
                        hb_age_next  = '0;
                    end
                    else if (frame_id == req_id_reg && req_ok)
                    begin
                        push = 1'b1;
                        priority if (b[1] == SID_READ_DID)
                        begin
                            if (pci_len < 4'd3)
                            begin
                                entry.len  = 4'd4;
                                entry.data = {32'h0, NRC_NOT_SUPP, b[1], NEG_RESP, 8'h03};
                            end
                            else if (did == did_first_reg)
                            begin
                                entry.len  = 4'd5;
                                entry.data = {24'h0, 1'b0, st_first_reg, b[3], b[2],
                                              SID_READ_DID | POS_OFFSET, 8'h04};
                            end
                            else if (did == did_second_reg)
                            begin
                                entry.len  = 4'd5;
                                entry.data = {24'h0, 2'b00, st_second_reg, b[3], b[2],
                                              SID_READ_DID | POS_OFFSET, 8'h04};
                            end
                            else
                            begin
                                entry.len  = 4'd4;
                                entry.data = {32'h0, NRC_RANGE, b[1], NEG_RESP, 8'h03};
                            end
                        end
                        else if (b[1] == SID_READ_DTC)
                        begin
                            if (fault_reg)
                            begin
                                entry.len  = 4'd6;
                                entry.data = {16'h0, DTC_STATUS, FAULT_CODE[7:0],
                                              FAULT_CODE[15:8],
                                              (pci_len >= 4'd2) ? b[2] : DTC_SUB_DEF,
                                              SID_READ_DTC | POS_OFFSET, 8'h05};
                            end
                            else
                            begin
                                entry.len  = 4'd3;
                                entry.data = {40'h0,
                                              (pci_len >= 4'd2) ? b[2] : DTC_SUB_DEF,
                                              SID_READ_DTC | POS_OFFSET, 8'h02};
                            end
                        end
                        else if (b[1] == SID_CLEAR_DTC)
                        begin
                            fault_next = 1'b0;
                            entry.len  = 4'd2;
                            entry.data = {48'h0, SID_CLEAR_DTC | POS_OFFSET, 8'h01};
                        end
                        else
                        begin
                            entry.len  = 4'd4;
                            entry.data = {32'h0, NRC_NOT_SUPP, b[1], NEG_RESP, 8'h03};
                        end
                    end
                end
                OP_MS:
                begin
                    if (hb_seen_reg && hb_age_reg != AGE_MAX)
                    begin
                        hb_age_next = hb_age_reg + 16'd1;
                    end
                end
                OP_STATUS:
                begin
                    push           = 1'b1;
                    st_first_next  = sample_first;
                    st_second_next = sample_second;
                    entry.id       = status_id_reg;
                    entry.len      = STATUS_LEN;
                    entry.data     = {47'h0, stale_flag, 2'b00, sample_second,
                                      1'b0, sample_first};
                    if (hb_seen_reg)
                    begin
                        if (hb_age_reg > timeout_reg && !fault_reg)
                        begin
                            fault_next  = 1'b1;
                            entry.alert = 1'b1;
                        end
                        else if (hb_age_reg <= timeout_reg && fault_reg)
                        begin
                            fault_next = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hb_seen_reg   <= 1'b0;
            hb_age_reg    <= '0;
            fault_reg     <= 1'b0;
            st_first_reg  <= '0;
            st_second_reg <= '0;
        end
        else
        begin
            hb_seen_reg   <= hb_seen_next;
            hb_age_reg    <= hb_age_next;
            fault_reg     <= fault_next;
            st_first_reg  <= st_first_next;
            st_second_reg <= st_second_next;
        end
    end

endmodule

@@ rtl/core/cdr_back.sv @@
`timescale 1ns / 1ps

module cdr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  cdr_pkg::cdr_entry_t head,
    input  cdr_pkg::cdr_qstat_t qstat,
    input  logic [10:0]         alert_id,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [79:0]         m_tdata,
    output logic                m_tlast
);
    import cdr_pkg::*;

    logic        valid_reg, valid_next;
    logic        pend_reg, pend_next;
    logic [10:0] id_reg, id_next;
    logic [3:0]  len_reg, len_next;
    logic [63:0] data_reg, data_next;
    logic        last_reg, last_next;
    logic        load;

    assign load     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, data_reg, len_reg, id_reg};
    assign m_tlast  = last_reg;

    always_comb
    begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        priority if (load && pend_reg)
        begin
            // trailing alert of a status tick
            valid_next = 1'b1;
            pend_next  = 1'b0;
            id_next    = alert_id;
            len_next   = ALERT_LEN;
            data_next  = {48'h0, FAULT_CODE[7:0], PARTNER_CODE};
            last_next  = 1'b1;
        end
        else if (load && !qstat.empty)
        begin
            pop        = 1'b1;
            valid_next = 1'b1;
            pend_next  = head.alert;
            id_next    = head.id;
            len_next   = head.len;
            data_next  = head.data;
            last_next  = !head.alert;
        end
        else if (load)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        len_reg  <= len_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

endmodule

@@ rtl/core/can_diag_responder_with_heartbeat_watch.sv @@
`timescale 1ns / 1ps

// Single-frame UDS diagnostic server with a partner heartbeat watchdog.
// Input requests carry one event each: a received CAN frame, a 1 ms tick or a
// status tick with a telemetry sample (kind in s_tuser). The front end takes
// one request per clock whenever its 4-entry job queue has room, updates the
// heartbeat age, fault flag and stored samples at once, and queues the frame
// to send. The back end drains the queue through an output register at one
// frame per clock while m_tready is high; a status tick that raises the fault
// gives two frames (status, then alert) on consecutive beats, tlast on the
// alert. The first frame of a request passes through the job queue and then
// the output register before m_tvalid rises. Millisecond ticks, heartbeats
// and ignored frames give no output. Config writes are always
// accepted (cfg_ready is tied high); indexes above 7 are dropped. Write them
// only while the block is idle.

module can_diag_responder_with_heartbeat_watch (
    input  logic                           clk,
    input  logic                           rst_n,
    // config write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cdr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cdr_pkg::CFG_DATA_W-1:0] cfg_data,
    // input events
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [10:0] frame_id, [14:11] frame_len, [78:15] frame_data,
    // [85:79] sample_first, [91:86] sample_second, [92] stale_flag
    input  logic [95:0]                    s_tdata,
    // [1:0] opcode
    input  logic [1:0]                     s_tuser,
    // frames to transmit
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [10:0] tx_id, [14:11] tx_len, [78:15] tx_data
    output logic [79:0]                    m_tdata,
    output logic                           m_tlast
);
    import cdr_pkg::*;

    logic       in_take;
    logic       push;
    logic       pop;
    cdr_entry_t wr_entry;
    cdr_entry_t head;
    cdr_qstat_t qstat;
    logic [10:0] alert_id;

    assign cfg_ready = 1'b1;
    assign s_tready  = !qstat.full;
    assign in_take   = s_tvalid && s_tready;

    cdr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_take       (in_take),
        .opcode        (s_tuser),
        .frame_id      (s_tdata[10:0]),
        .frame_len     (s_tdata[14:11]),
        .frame_data    (s_tdata[78:15]),
        .sample_first  (s_tdata[85:79]),
        .sample_second (s_tdata[91:86]),
        .stale_flag    (s_tdata[92]),
        .push          (push),
        .entry         (wr_entry),
        .alert_id      (alert_id)
    );

    cdr_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .rd_entry (head),
        .stat     (qstat)
    );

    cdr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .qstat    (qstat),
        .alert_id (alert_id),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ rtl/core/cdr_checker.sv @@
`timescale 1ns / 1ps

module cdr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic        m_tlast
);
    import cdr_pkg::*;

    // stalled output frame holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output frame changed while stalled");

    // only a status frame can be followed by more frames of the same event
    a_nonlast_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[14:11] == STATUS_LEN)
        else $error("non-final frame is not a status frame");

    // the alert follows its status frame on the very next beat
    a_alert_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && m_tlast && m_tdata[14:11] == ALERT_LEN
            && m_tdata[30:15] == {FAULT_CODE[7:0], PARTNER_CODE})
        else $error("alert frame missing after status frame");

    // DLC stays within a classic CAN frame
    a_dlc: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[14:11] <= 4'd8)
        else $error("transmit DLC above 8");

endmodule

bind can_diag_responder_with_heartbeat_watch cdr_checker u_cdr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
